// File: src/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared constants for the sorted table binary search core.
// ----------------------------------------------------------------------------
package stbs_pkg;

   localparam int VALUE_W = 32;   // width of a stored value or search key
   localparam int RSP_W   = 5;    // width of the position and count outputs

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

endpackage

// File: src/stbs_ram.sv
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/sorted_table_binary_search_core.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Collects signed values into a table, sorts them ascending with an early-exit
// bubble sort when a set closes, and answers binary-search lookups.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | word
//  --------+----------------------+------------------------------------------
//  req     | req_valid/req_ready  | command, value, last
//  rsp     | rsp_valid/rsp_ready  | found, position, count, overflow
//
//  Flow: an append without last goes from idle straight to the response
//  state. A search alternates between the check and compare states until it
//  hits or the range is empty, then responds. A closing append of a set with
//  more than one value adds the sort: each bubble pass goes through the single
//  table RAM read port and the one shared compare unit.
//  Reset clears the count, the closed flag and the response valid; table
//  contents stay undefined until written. req_ready is high only in idle; a
//  stalled response holds the core in its response state.
//
module sorted_table_binary_search_core #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_command,
   input  logic signed [stbs_pkg::VALUE_W-1:0] req_value,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_found,
   output logic [stbs_pkg::RSP_W-1:0]         rsp_position,
   output logic [stbs_pkg::RSP_W-1:0]         rsp_count,
   output logic                               rsp_overflow
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int VW = stbs_pkg::VALUE_W;
   localparam int RW = stbs_pkg::RSP_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SORT_START,
      S_SORT_FIRST,
      S_SORT_CMP,
      S_SORT_END,
      S_SRCH_CHK,
      S_SRCH_CMP,
      S_RESP
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                closed_ff, closed_in;
   logic [CW-1:0]       pass_ff, pass_in;
   logic [AW-1:0]       k_ff, k_in;
   logic                swapped_ff, swapped_in;
   logic signed [VW-1:0] cur_ff, cur_in;
   logic signed [VW-1:0] key_ff, key_in;
   logic [CW-1:0]       lo_ff, lo_in;
   logic [CW-1:0]       end_ff, end_in;
   logic [CW-1:0]       mid_ff, mid_in;
   logic                hit_ff, hit_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic                ovf_ff, ovf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [RW-1:0]       rsp_position_ff, rsp_position_in;
   logic [RW-1:0]       rsp_count_ff, rsp_count_in;
   logic                rsp_overflow_ff, rsp_overflow_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [VW-1:0]       wr_data;
   logic [AW-1:0]       rd_addr;
   logic [VW-1:0]       rd_data;
   logic signed [VW-1:0] rd_value;

   logic [CW-1:0]       base_count;
   logic [CW-1:0]       last_idx;
   logic [CW:0]         mid_sum;
   logic [CW-1:0]       mid_calc;
   logic                cur_gt;
   logic [CW+RW-1:0]    count_wide;
   logic [CW+RW-1:0]    pos_wide;

   stbs_ram #(
      .WIDTH (VW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_value   = $signed(rd_data);
   // the one shared compare: carried element or key against the read word
   assign cur_gt     = (state_ff == S_SORT_CMP) ? (cur_ff > rd_value) : (rd_value > key_ff);
   // an append after a closed set starts over at zero
   assign base_count = closed_ff ? '0 : count_ff;
   // last index touched by the current bubble pass
   assign last_idx   = count_ff - pass_ff;
   // floor((lo + hi) / 2) with hi = end - 1; lo < end whenever it is used
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, end_ff} - {{CW{1'b0}}, 1'b1};
   assign mid_calc   = mid_sum[CW:1];
   // outputs are masked to RW bits
   assign count_wide = {{RW{1'b0}}, count_ff};
   assign pos_wide   = {{RW{1'b0}}, pos_ff};

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      closed_in       = closed_ff;
      pass_in         = pass_ff;
      k_in            = k_ff;
      swapped_in      = swapped_ff;
      cur_in          = cur_ff;
      key_in          = key_ff;
      lo_in           = lo_ff;
      end_in          = end_ff;
      mid_in          = mid_ff;
      hit_in          = hit_ff;
      pos_in          = pos_ff;
      ovf_in          = ovf_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_overflow_in = rsp_overflow_ff;
      wr_en           = 1'b0;
      wr_addr         = '0;
      wr_data         = '0;
      rd_addr         = '0;

      // drop the response word once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               hit_in = 1'b0;
               pos_in = '0;
               ovf_in = 1'b0;
               key_in = req_value;
               if (req_command == stbs_pkg::CMD_APPEND) begin
                  // write straight into the table; full table drops the word
                  count_in = base_count;
                  if (base_count < CW'(TABLE_DEPTH)) begin
                     wr_en    = 1'b1;
                     wr_addr  = base_count[AW-1:0];
                     wr_data  = req_value;
                     count_in = base_count + CW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  closed_in = req_last;
                  pass_in   = CW'(1);
                  if (req_last && count_in > CW'(1)) begin
                     state_in = S_SORT_START;
                  end else begin
                     state_in = S_RESP;
                  end
               end else begin
                  lo_in    = '0;
                  end_in   = count_ff;
                  state_in = S_SRCH_CHK;
               end
            end
         end

         S_SORT_START: begin
            // fetch the first element of the pass
            rd_addr    = '0;
            swapped_in = 1'b0;
            state_in   = S_SORT_FIRST;
         end

         S_SORT_FIRST: begin
            cur_in   = rd_value;
            rd_addr  = AW'(1);
            k_in     = AW'(1);
            state_in = S_SORT_CMP;
         end

         S_SORT_CMP: begin
            // carry the larger element forward; settle the smaller at k-1
            if (cur_gt) begin
               wr_en      = 1'b1;
               wr_addr    = k_ff - AW'(1);
               wr_data    = rd_data;
               swapped_in = 1'b1;
            end else begin
               cur_in = rd_value;
               if (swapped_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = k_ff - AW'(1);
                  wr_data = cur_ff;
               end
            end
            if (CW'(k_ff) == last_idx) begin
               state_in = S_SORT_END;
            end else begin
               k_in     = k_ff + AW'(1);
               rd_addr  = k_ff + AW'(1);
            end
         end

         S_SORT_END: begin
            // the carried element is the largest of this pass
            wr_en   = 1'b1;
            wr_addr = last_idx[AW-1:0];
            wr_data = cur_ff;
            if (!swapped_ff || (pass_ff + CW'(1)) >= count_ff) begin
               state_in = S_RESP;
            end else begin
               pass_in  = pass_ff + CW'(1);
               state_in = S_SORT_START;
            end
         end

         S_SRCH_CHK: begin
            if (lo_ff < end_ff) begin
               mid_in   = mid_calc;
               rd_addr  = mid_calc[AW-1:0];
               state_in = S_SRCH_CMP;
            end else begin
               state_in = S_RESP;
            end
         end

         S_SRCH_CMP: begin
            if (rd_value == key_ff) begin
               hit_in   = 1'b1;
               pos_in   = mid_ff + CW'(1);
               state_in = S_RESP;
            end else begin
               if (cur_gt) begin
                  end_in = mid_ff;
               end else begin
                  lo_in = mid_ff + CW'(1);
               end
               state_in = S_SRCH_CHK;
            end
         end

         S_RESP: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = hit_ff;
               rsp_position_in = pos_wide[RW-1:0];
               rsp_count_in    = count_wide[RW-1:0];
               rsp_overflow_in = ovf_ff;
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pass_ff         <= pass_in;
      k_ff            <= k_in;
      swapped_ff      <= swapped_in;
      cur_ff          <= cur_in;
      key_ff          <= key_in;
      lo_ff           <= lo_in;
      end_ff          <= end_in;
      mid_ff          <= mid_in;
      hit_ff          <= hit_in;
      pos_ff          <= pos_in;
      ovf_ff          <= ovf_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule
